>>> src/i2ctrm_pkg.sv
// Shared types, constants and codes for the I2C target register map.
`default_nettype none
package i2ctrm_pkg;

    localparam int MAP_SIZE_DEF      = 256;
    localparam int STATUS_SLOT_DEF   = 240;
    localparam int VALUE_LO_SLOT_DEF = 241;
    localparam int TARGET_SLOT_DEF   = 242;
    localparam int VALUE_HI_SLOT_DEF = 243;

    localparam logic [2:0] REQ_INDEX = 3'd0;
    localparam logic [2:0] REQ_DATA  = 3'd1;
    localparam logic [2:0] REQ_READ  = 3'd2;
    localparam logic [2:0] REQ_LWR   = 3'd3;
    localparam logic [2:0] REQ_LRD   = 3'd4;

    localparam logic [7:0] CMD_START = 8'hFE;
    localparam logic [7:0] CMD_SUB   = 8'h5D;
    localparam logic [7:0] ST_POLLED = 8'h02;
    localparam logic [7:0] ST_START  = 8'h03;
    localparam logic [7:0] ST_SUB    = 8'h04;
    localparam logic [7:0] ST_TARGET = 8'h05;
    localparam logic [7:0] ST_HI     = 8'h06;
    localparam logic [7:0] ST_LO     = 8'h07;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SUB    = 3'd1;
    localparam logic [2:0] PH_TARGET = 3'd2;
    localparam logic [2:0] PH_HI     = 3'd3;
    localparam logic [2:0] PH_LO     = 3'd4;
    localparam logic [2:0] PH_LOG    = 3'd5;

    // operations the back end executes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_INDEX = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_LWR   = 3'd4;
    localparam logic [2:0] OP_LRD   = 3'd5;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] bus_byte;
        logic [7:0] local_addr;
        logic [7:0] local_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       accepted;
    } t_out_item;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] bus_byte;
        logic [7:0] local_addr;
        logic [7:0] local_data;
    } t_op_item;

endpackage
`default_nettype wire

>>> src/i2ctrm_front.sv
// Front end: accepts items, classifies them and queues operations.
`default_nettype none
module i2ctrm_front
    import i2ctrm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_bus_enable,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_op_valid,
    input  wire logic     i_op_ready,
    output t_op_item      o_op
);
    localparam int QD = 2;

    t_op_item   r_q [QD];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op_item   w_op;
    logic       w_push, w_pop;

    always_comb begin
        w_op.bus_byte   = i_item.bus_byte;
        w_op.local_addr = i_item.local_addr;
        w_op.local_data = i_item.local_data;
        priority case (1'b1)
            i_item.req_type == REQ_INDEX && i_bus_enable: w_op.op = OP_INDEX;
            i_item.req_type == REQ_DATA  && i_bus_enable: w_op.op = OP_DATA;
            i_item.req_type == REQ_READ  && i_bus_enable: w_op.op = OP_READ;
            i_item.req_type == REQ_LWR:                   w_op.op = OP_LWR;
            i_item.req_type == REQ_LRD:                   w_op.op = OP_LRD;
            default:                                      w_op.op = OP_NONE;
        endcase
    end

    assign o_ready    = r_cnt != 2'(QD);
    assign o_op_valid = r_cnt != 2'd0;
    assign o_op       = r_q[r_rp];
    assign w_push     = i_valid && o_ready;
    assign w_pop      = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QD)) else $error("queue overflow");
    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> r_wp == r_rp) else $error("pointer mismatch");
    a_full_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(QD) |-> r_wp == r_rp) else $error("pointer mismatch full");
endmodule
`default_nettype wire

>>> src/i2ctrm_back.sv
// Back end: executes queued operations against the map and sequencer.
`default_nettype none
module i2ctrm_back
    import i2ctrm_pkg::*;
#(
    parameter int MAP_SIZE      = MAP_SIZE_DEF,
    parameter int STATUS_SLOT   = STATUS_SLOT_DEF,
    parameter int VALUE_LO_SLOT = VALUE_LO_SLOT_DEF,
    parameter int TARGET_SLOT   = TARGET_SLOT_DEF,
    parameter int VALUE_HI_SLOT = VALUE_HI_SLOT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_op_valid,
    output logic          o_op_ready,
    input  wire t_op_item i_op,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_item
);
    localparam logic [7:0] S_ST = 8'(STATUS_SLOT);
    localparam logic [7:0] S_LO = 8'(VALUE_LO_SLOT);
    localparam logic [7:0] S_TG = 8'(TARGET_SLOT);
    localparam logic [7:0] S_HI = 8'(VALUE_HI_SLOT);
    localparam logic [8:0] MSZ  = 9'(MAP_SIZE);
    localparam logic [8:0] LAST = 9'(MAP_SIZE - 1);

    // general map with valid bits; fixed slots kept in registers
    logic [7:0] r_map [256];
    logic [255:0] r_vld;
    logic [7:0] r_st, r_lo, r_tg, r_hi;
    logic [8:0] r_ptr;
    logic [2:0] r_ph;
    logic       r_ovalid;
    t_out_item  r_out;
    logic       r_busy;
    t_op_item   r_op;
    logic [7:0] r_mdat;
    logic       r_mok;

    logic       w_go;
    logic       w_ex;
    logic       w_wr;
    logic [7:0] w_wa, w_wd, w_ra, w_xa, w_rd, w_mrd;
    logic [8:0] w_pinc;
    logic       w_poll;

    assign o_op_ready = !r_busy;
    assign w_go       = i_op_valid && o_op_ready;
    assign w_ex       = r_busy && (!r_ovalid || i_ready);
    assign o_valid    = r_ovalid;
    assign o_item     = r_out;
    assign w_pinc     = r_ptr + 9'd1;
    assign w_ra       = (i_op.op == OP_LRD) ? i_op.local_addr : r_ptr[7:0];
    assign w_xa       = (r_op.op == OP_LRD) ? r_op.local_addr : r_ptr[7:0];

    function automatic logic [7:0] rd_slot(input logic [7:0] a, input logic [7:0] m,
                                           input logic [7:0] st, input logic [7:0] lo,
                                           input logic [7:0] tg, input logic [7:0] hi);
        logic [7:0] v;
        v = m;
        if (a == S_HI) v = hi;
        if (a == S_TG) v = tg;
        if (a == S_LO) v = lo;
        if (a == S_ST) v = st;
        return v;
    endfunction

    assign w_mrd  = r_mok ? r_mdat : 8'd0;
    assign w_rd   = rd_slot(w_xa, w_mrd, r_st, r_lo, r_tg, r_hi);
    assign w_poll = r_st != 8'd0 && r_ptr == {1'b0, r_tg} && r_lo != 8'd0;

    always_comb begin
        w_wr = 1'b0;
        w_wa = r_ptr[7:0];
        w_wd = r_op.bus_byte;
        if (w_ex && r_op.op == OP_LWR && {1'b0, r_op.local_addr} < MSZ) begin
            w_wr = 1'b1;
            w_wa = r_op.local_addr;
            w_wd = r_op.local_data;
        end else if (w_ex && r_op.op == OP_DATA && r_ph != PH_SUB
                     && r_ph != PH_TARGET && r_ph != PH_HI && r_ph != PH_LO
                     && r_ptr < MSZ) begin
            w_wr = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_map[w_wa] <= w_wd;
        end
        if (w_go) begin
            r_mdat <= r_map[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_st     <= 8'd0;
            r_lo     <= 8'd0;
            r_tg     <= 8'd0;
            r_hi     <= 8'd0;
            r_ptr    <= 9'd0;
            r_ph     <= PH_IDLE;
            r_ovalid <= 1'b0;
            r_out    <= '0;
            r_busy   <= 1'b0;
            r_op     <= '0;
            r_mok    <= 1'b0;
        end else begin
            if (w_ex) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_go) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_mok  <= r_vld[w_ra];
            end
            if (w_wr) begin
                r_vld[w_wa] <= 1'b1;
                if (w_wa == S_HI) r_hi <= w_wd;
                if (w_wa == S_TG) r_tg <= w_wd;
                if (w_wa == S_LO) r_lo <= w_wd;
                if (w_wa == S_ST) r_st <= w_wd;
            end
            if (w_ex) begin
                r_busy          <= 1'b0;
                r_out.accepted  <= r_op.op != OP_NONE;
                r_out.read_data <= 8'd0;
                unique case (r_op.op)
                    OP_INDEX: begin
                        if (r_op.bus_byte == CMD_START) begin
                            r_ph <= PH_SUB;
                            r_st <= ST_START;
                        end else begin
                            r_ptr <= {1'b0, r_op.bus_byte};
                            r_ph  <= PH_LOG;
                        end
                    end
                    OP_DATA: begin
                        unique case (r_ph)
                            PH_SUB: begin
                                if (r_op.bus_byte == CMD_SUB) begin
                                    r_ph <= PH_TARGET;
                                    r_st <= ST_SUB;
                                end else begin
                                    r_ph <= PH_IDLE;
                                end
                            end
                            PH_TARGET: begin
                                r_tg <= r_op.bus_byte;
                                r_ph <= PH_HI;
                                r_st <= ST_TARGET;
                            end
                            PH_HI: begin
                                r_hi <= r_op.bus_byte;
                                r_ph <= PH_LO;
                                r_st <= ST_HI;
                            end
                            PH_LO: begin
                                r_lo <= r_op.bus_byte;
                                r_ph <= PH_IDLE;
                                r_st <= ST_LO;
                            end
                            default: begin
                                if (r_ptr < MSZ) begin
                                    r_ptr <= w_pinc;
                                end
                            end
                        endcase
                    end
                    OP_READ: begin
                        if (w_poll) begin
                            r_out.read_data <= r_lo;
                            r_lo <= 8'd0;
                            r_st <= ST_POLLED;
                        end else if (r_ptr < MSZ) begin
                            r_out.read_data <= w_rd;
                        end
                        r_ptr <= (w_pinc >= MSZ) ? LAST : w_pinc;
                    end
                    OP_LRD: begin
                        if ({1'b0, r_op.local_addr} < MSZ) begin
                            r_out.read_data <= w_rd;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_out)) else $error("result lost");
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_out.accepted |-> r_out.read_data == 8'd0) else $error("bad reject");
    a_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ex && r_op.op == OP_READ && w_poll |=> r_lo == 8'd0 && r_st == ST_POLLED)
        else $error("poll not cleared");
endmodule
`default_nettype wire

>>> src/i2c_target_register_map.sv
// Top level of the I2C target register map.
// Byte-level I2C target with a 256-entry register map, auto-incrementing pointer and command
// sequencer. A front queue of two entries classifies items; the back end works on one item at
// a time, first a registered map read and then the update, and takes no new item until that
// item's result is registered. A result held by the receiver stalls the back end.
// No clearing pass is needed after reset; map entries read as zero until written.
`default_nettype none
module i2c_target_register_map
    import i2ctrm_pkg::*;
#(
    parameter int MAP_SIZE      = MAP_SIZE_DEF,
    parameter int STATUS_SLOT   = STATUS_SLOT_DEF,
    parameter int VALUE_LO_SLOT = VALUE_LO_SLOT_DEF,
    parameter int TARGET_SLOT   = TARGET_SLOT_DEF,
    parameter int VALUE_HI_SLOT = VALUE_HI_SLOT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_item
);
    logic     r_bus_enable;
    logic     w_op_valid, w_op_ready;
    t_op_item w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_bus_enable <= i_cfg_wdata;
        end
    end

    i2ctrm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bus_enable (r_bus_enable),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (i_item),
        .o_op_valid   (w_op_valid),
        .i_op_ready   (w_op_ready),
        .o_op         (w_op)
    );

    i2ctrm_back #(
        .MAP_SIZE      (MAP_SIZE),
        .STATUS_SLOT   (STATUS_SLOT),
        .VALUE_LO_SLOT (VALUE_LO_SLOT),
        .TARGET_SLOT   (TARGET_SLOT),
        .VALUE_HI_SLOT (VALUE_HI_SLOT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .o_op_ready (w_op_ready),
        .i_op       (w_op),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );
endmodule
`default_nettype wire

>>> verif/i2c_target_register_map_tb.sv
// Self-checking testbench for the I2C target register map: directed table, then random traffic.
`timescale 1ns / 100ps
module i2c_target_register_map_tb;
    import i2ctrm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0] req_type;
        logic [7:0] bus_byte;
        logic [7:0] local_addr;
        logic [7:0] local_data;
        logic       known;
        logic [7:0] exp_data;
        logic       exp_acc;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic      i_cfg_wdata;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    i2c_target_register_map dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    logic [7:0] map_model [256];
    logic [8:0] ptr_model;
    logic [2:0] phase_model;
    logic       enable_model;

    t_out_item  pending_results[$];
    t_row       table_rows[$];
    int         fail_count;
    int         cycle_count;
    bit         stall_long;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_out_item predict_reply(t_in_item it);
        t_out_item r;
        logic [7:0] b;
        r.read_data = 8'd0;
        r.accepted  = 1'b0;
        b = it.bus_byte;
        if (it.req_type <= REQ_READ && enable_model) begin
            r.accepted = 1'b1;
            if (it.req_type == REQ_INDEX) begin
                if (b == CMD_START) begin
                    phase_model = PH_SUB;
                    map_model[STATUS_SLOT_DEF] = ST_START;
                end else begin
                    ptr_model   = {1'b0, b};
                    phase_model = PH_LOG;
                end
            end else if (it.req_type == REQ_DATA) begin
                case (phase_model)
                    PH_SUB: begin
                        if (b == CMD_SUB) begin
                            phase_model = PH_TARGET;
                            map_model[STATUS_SLOT_DEF] = ST_SUB;
                        end else begin
                            phase_model = PH_IDLE;
                        end
                    end
                    PH_TARGET: begin
                        map_model[TARGET_SLOT_DEF] = b;
                        phase_model = PH_HI;
                        map_model[STATUS_SLOT_DEF] = ST_TARGET;
                    end
                    PH_HI: begin
                        map_model[VALUE_HI_SLOT_DEF] = b;
                        phase_model = PH_LO;
                        map_model[STATUS_SLOT_DEF] = ST_HI;
                    end
                    PH_LO: begin
                        map_model[VALUE_LO_SLOT_DEF] = b;
                        phase_model = PH_IDLE;
                        map_model[STATUS_SLOT_DEF] = ST_LO;
                    end
                    default: begin
                        if (ptr_model < MAP_SIZE_DEF) begin
                            map_model[ptr_model[7:0]] = b;
                            ptr_model = ptr_model + 9'd1;
                        end
                    end
                endcase
            end else begin
                if (map_model[STATUS_SLOT_DEF] != 8'd0
                        && ptr_model == {1'b0, map_model[TARGET_SLOT_DEF]}
                        && map_model[VALUE_LO_SLOT_DEF] != 8'd0) begin
                    r.read_data = map_model[VALUE_LO_SLOT_DEF];
                    map_model[VALUE_LO_SLOT_DEF] = 8'd0;
                    map_model[STATUS_SLOT_DEF]   = ST_POLLED;
                end else if (ptr_model < MAP_SIZE_DEF) begin
                    r.read_data = map_model[ptr_model[7:0]];
                end
                ptr_model = ptr_model + 9'd1;
                if (ptr_model >= MAP_SIZE_DEF)
                    ptr_model = 9'(MAP_SIZE_DEF - 1);
            end
        end else if (it.req_type == REQ_LWR) begin
            r.accepted = 1'b1;
            map_model[it.local_addr] = it.local_data;
        end else if (it.req_type == REQ_LRD) begin
            r.accepted  = 1'b1;
            r.read_data = map_model[it.local_addr];
        end
        return r;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n != 0)
            i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(t_in_item it, bit known, logic [7:0] ed, logic ea);
        t_out_item r;
        r = predict_reply(it);
        if (known && (r.read_data !== ed || r.accepted !== ea)) begin
            $error("table row disagrees with prediction: read_data %0h/%0h", ed, r.read_data);
            fail_count++;
        end
        pending_results.push_back(r);
        i_item  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_enable(logic v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        enable_model = v;
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        it.bus_byte   = 8'($urandom);
        it.local_addr = 8'($urandom);
        it.local_data = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)
            it.req_type = REQ_DATA;
        else if (pick < 45)
            it.req_type = REQ_READ;
        else if (pick < 60)
            it.req_type = REQ_INDEX;
        else if (pick < 75)
            it.req_type = REQ_LWR;
        else if (pick < 95)
            it.req_type = REQ_LRD;
        else
            it.req_type = 3'($urandom_range(5, 7));
        if (it.req_type == REQ_INDEX && $urandom_range(0, 2) == 0)
            it.bus_byte = CMD_START;
        if ($urandom_range(0, 3) == 0)
            it.local_addr = 8'($urandom_range(236, 247));
        return it;
    endfunction

    task automatic send_command(logic [7:0] tgt);
        t_in_item it;
        it = random_item();
        it.req_type = REQ_INDEX;
        it.bus_byte = CMD_START;
        send_item(it, 0, 0, 0);
        idle_gap();
        it.req_type = REQ_DATA;
        it.bus_byte = ($urandom_range(0, 5) == 0) ? 8'($urandom) : CMD_SUB;
        send_item(it, 0, 0, 0);
        it.bus_byte = tgt;
        send_item(it, 0, 0, 0);
        it.bus_byte = 8'($urandom);
        send_item(it, 0, 0, 0);
        it.bus_byte = 8'($urandom);
        send_item(it, 0, 0, 0);
        it.req_type = REQ_INDEX;
        it.bus_byte = ($urandom_range(0, 1) == 0) ? tgt : tgt - 8'd1;
        send_item(it, 0, 0, 0);
        it.req_type = REQ_READ;
        repeat ($urandom_range(1, 3)) send_item(it, 0, 0, 0);
    endtask

    function automatic void add_row(logic [2:0] ty, logic [7:0] b, logic [7:0] la,
                                    logic [7:0] ld, logic k, logic [7:0] ed, logic ea);
        t_row r;
        r.req_type = ty; r.bus_byte = b; r.local_addr = la; r.local_data = ld;
        r.known = k; r.exp_data = ed; r.exp_acc = ea;
        table_rows.push_back(r);
    endfunction

    // receiver
    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_long) begin
                i_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                stall_long = 0;
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 1);
            if ($urandom_range(0, 2) == 0)
                n = 0;
            if (n != 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected item: read_data %0h accepted %0b",
                       o_item.read_data, o_item.accepted);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_item.read_data !== e.read_data) begin
                    $error("read_data expected %0h actual %0h", e.read_data, o_item.read_data);
                    fail_count++;
                end
                if (o_item.accepted !== e.accepted) begin
                    $error("accepted expected %0b actual %0b", e.accepted, o_item.accepted);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b1;
        i_valid     = 1'b0;
        i_item      = '0;
        fail_count  = 0;
        cycle_count = 0;
        stall_long  = 0;
        for (int i = 0; i < 256; i++)
            map_model[i] = 8'd0;
        ptr_model    = 9'd0;
        phase_model  = PH_IDLE;
        enable_model = 1'b1;

        add_row(REQ_READ,  8'h00, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_LRD,   8'h00, 8'hFF, 8'h00, 1, 8'h00, 1);
        add_row(REQ_LWR,   8'h00, 8'hFF, 8'hFF, 1, 8'h00, 1);
        add_row(REQ_LRD,   8'h00, 8'hFF, 8'h00, 1, 8'hFF, 1);
        add_row(REQ_LWR,   8'h00, 8'h00, 8'hA5, 1, 8'h00, 1);
        add_row(3'd5,      8'hFF, 8'hFF, 8'hFF, 1, 8'h00, 0);
        add_row(3'd7,      8'h00, 8'h00, 8'h00, 1, 8'h00, 0);
        add_row(REQ_INDEX, 8'hFF, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_DATA,  8'h11, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_READ,  8'h00, 8'h00, 8'h00, 0, 8'h00, 0);
        add_row(REQ_READ,  8'h00, 8'h00, 8'h00, 0, 8'h00, 0);
        add_row(REQ_INDEX, CMD_START, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_DATA,  8'h00, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_INDEX, CMD_START, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_DATA,  CMD_SUB, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_DATA,  8'h20, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_DATA,  8'h12, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_DATA,  8'h34, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_LRD,   8'h00, 8'(STATUS_SLOT_DEF), 8'h00, 1, ST_LO, 1);
        add_row(REQ_INDEX, 8'h20, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_READ,  8'h00, 8'h00, 8'h00, 1, 8'h34, 1);
        add_row(REQ_LRD,   8'h00, 8'(STATUS_SLOT_DEF), 8'h00, 1, ST_POLLED, 1);
        add_row(REQ_INDEX, 8'h00, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_DATA,  8'h00, 8'h00, 8'h00, 1, 8'h00, 1);
        add_row(REQ_READ,  8'h00, 8'h00, 8'h00, 0, 8'h00, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) begin
            it.req_type   = table_rows[k].req_type;
            it.bus_byte   = table_rows[k].bus_byte;
            it.local_addr = table_rows[k].local_addr;
            it.local_data = table_rows[k].local_data;
            send_item(it, table_rows[k].known, table_rows[k].exp_data,
                      table_rows[k].exp_acc);
            idle_gap();
        end

        write_enable(1'b0);
        for (int k = 0; k < 20; k++) begin
            it = random_item();
            send_item(it, 0, 0, 0);
        end
        write_enable(1'b1);

        stall_long = 1;
        for (int k = 0; k < 40; k++) begin
            it = random_item();
            send_item(it, 0, 0, 0);
        end
        drain();

        for (int k = 0; k < 1000; ) begin
            if (k % 250 == 125) begin
                write_enable(1'b0);
                repeat (15) begin
                    it = random_item();
                    send_item(it, 0, 0, 0);
                end
                write_enable(1'b1);
            end
            if ($urandom_range(0, 4) == 0) begin
                send_command(($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom));
                k += 8;
            end else begin
                it = random_item();
                send_item(it, 0, 0, 0);
                k++;
            end
            if ($urandom_range(0, 2) == 0)
                idle_gap();
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> files.f
src/i2ctrm_pkg.sv
src/i2ctrm_front.sv
src/i2ctrm_back.sv
src/i2c_target_register_map.sv
verif/i2c_target_register_map_tb.sv
